// File: rtl/huffman_code_packer_unit_assert.svh
// Assertion macros shared by the packer modules.
// Define NO_ASSERTIONS to compile them out.
`ifndef HUFFMAN_CODE_PACKER_UNIT_ASSERT_SVH
`define HUFFMAN_CODE_PACKER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked at every rising clock edge, ignored while reset is asserted.
`define HCP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("huffman code packer assertion failed");

// Checked at every rising clock edge, reset included.
`define HCP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("huffman code packer assertion failed");

`else

`define HCP_ASSERT(lbl, clk, rst_n, prop)
`define HCP_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: rtl/hcp_pkg.sv
package hcp_pkg;

  // Fixed widths of the transaction fields.
  localparam int unsigned OP_W     = 2;
  localparam int unsigned SYM_W    = 8;
  localparam int unsigned CODE_W   = 64;
  localparam int unsigned LEN_IN_W = 7;
  localparam int unsigned CHUNK_W  = 64;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned VBITS_W  = 9;

  // Operation codes carried in the op field.
  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_e;

  // Table memory strobes.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } table_ctl_t;

  // Transaction handed to the packing stage.
  typedef struct packed {
    logic valid;
    op_e  op;
  } stage_req_t;

  // Word hand-off from the packing stage to the output buffer.
  typedef struct packed {
    logic               valid;
    logic [VBITS_W-1:0] valid_bits;
  } emit_req_t;

endpackage

// File: rtl/huffman_code_packer_unit.sv
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i / in_ready_o  op_i, symbol_i, code_bits_i, code_length_i
// out      output     out_valid_o / out_ready_i word_chunk_o, chunk_index_o, last_chunk_o,
//                                              valid_bits_o
//
// One transaction is accepted per cycle. An encode reads the code table in the cycle of
// acceptance and packs the code in the packing stage, so a transaction sees every
// earlier load. A flush or an overflowing encode emits one word as ceil(WORD_BITS/64)
// chunk transactions from the output buffer, one per cycle while out_ready_i is high;
// input stalls only when a second word is ready before the buffer drains.
// Reset clears the accumulator, fill count and handshake state; the code table
// holds no defined value until loaded.
module huffman_code_packer_unit #(
  parameter int unsigned WORD_BITS     = 256,
  parameter int unsigned MAX_CODE_BITS = 64,
  parameter int unsigned ALPHABET_SIZE = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [hcp_pkg::OP_W-1:0]      op_i,
  input  logic [hcp_pkg::SYM_W-1:0]     symbol_i,
  input  logic [hcp_pkg::CODE_W-1:0]    code_bits_i,
  input  logic [hcp_pkg::LEN_IN_W-1:0]  code_length_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [hcp_pkg::CHUNK_W-1:0]   word_chunk_o,
  output logic [hcp_pkg::IDX_W-1:0]     chunk_index_o,
  output logic                          last_chunk_o,
  output logic [hcp_pkg::VBITS_W-1:0]   valid_bits_o
);

  localparam int unsigned ADDR_W = $clog2(ALPHABET_SIZE);
  localparam int unsigned LEN_W  = $clog2(MAX_CODE_BITS + 1);

  logic                     in_fire;
  logic                     sym_ok;
  hcp_pkg::op_e             op;
  hcp_pkg::table_ctl_t      tbl_ctl;
  hcp_pkg::stage_req_t      stage_req;
  hcp_pkg::emit_req_t       emit;
  logic [MAX_CODE_BITS-1:0] rd_code;
  logic [LEN_W-1:0]         rd_len;
  logic [WORD_BITS-1:0]     emit_word;
  logic                     emit_ready;
  logic                     advance;

  assign in_ready_o = advance;
  assign in_fire    = in_valid_i && in_ready_o;
  assign op         = hcp_pkg::op_e'(op_i);
  assign sym_ok     = (hcp_pkg::SYM_W + 1)'(symbol_i) < (hcp_pkg::SYM_W + 1)'(ALPHABET_SIZE);

  // Decode the transaction into table strobes and a packing request.
  always_comb begin
    tbl_ctl   = '0;
    stage_req = '{valid: 1'b0, op: op};
    case (op)
      hcp_pkg::OP_LOAD: begin
        tbl_ctl.wr_en = in_fire && sym_ok;
      end
      hcp_pkg::OP_ENCODE: begin
        tbl_ctl.rd_en   = in_fire && sym_ok;
        stage_req.valid = in_fire && sym_ok;
      end
      hcp_pkg::OP_FLUSH: begin
        stage_req.valid = in_fire;
      end
      default: begin
        tbl_ctl   = '0;
        stage_req = '{valid: 1'b0, op: op};
      end
    endcase
  end

  hcp_table #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_table (
    .clk_i     (clk_i),
    .ctl_i     (tbl_ctl),
    .addr_i    (symbol_i[ADDR_W-1:0]),
    .wr_code_i (code_bits_i),
    .wr_len_i  (code_length_i),
    .rd_code_o (rd_code),
    .rd_len_o  (rd_len)
  );

  hcp_packer #(
    .WORD_BITS     (WORD_BITS),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_packer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (stage_req),
    .advance_o    (advance),
    .code_i       (rd_code),
    .len_i        (rd_len),
    .emit_o       (emit),
    .emit_word_o  (emit_word),
    .emit_ready_i (emit_ready)
  );

  hcp_out_buf #(
    .WORD_BITS (WORD_BITS)
  ) u_out_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .emit_i        (emit),
    .emit_word_i   (emit_word),
    .emit_ready_o  (emit_ready),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .word_chunk_o  (word_chunk_o),
    .chunk_index_o (chunk_index_o),
    .last_chunk_o  (last_chunk_o),
    .valid_bits_o  (valid_bits_o)
  );

endmodule

// File: rtl/hcp_table.sv
module hcp_table #(
  parameter int unsigned ALPHABET_SIZE = 256,
  parameter int unsigned MAX_CODE_BITS = 64,
  localparam int unsigned ADDR_W = $clog2(ALPHABET_SIZE),
  localparam int unsigned LEN_W  = $clog2(MAX_CODE_BITS + 1)
) (
  input  logic                          clk_i,
  input  hcp_pkg::table_ctl_t           ctl_i,
  input  logic [ADDR_W-1:0]             addr_i,
  input  logic [hcp_pkg::CODE_W-1:0]    wr_code_i,
  input  logic [hcp_pkg::LEN_IN_W-1:0]  wr_len_i,
  output logic [MAX_CODE_BITS-1:0]      rd_code_o,
  output logic [LEN_W-1:0]              rd_len_o
);

  localparam int unsigned ENTRY_W = LEN_W + MAX_CODE_BITS;

  logic [ENTRY_W-1:0]       mem_q [ALPHABET_SIZE];
  logic [ENTRY_W-1:0]       rd_q;
  logic [LEN_W-1:0]         len_sat;
  logic [MAX_CODE_BITS-1:0] code_masked;

  // Saturate the length and clear code bits above it before the write.
  always_comb begin
    if (wr_len_i > hcp_pkg::LEN_IN_W'(MAX_CODE_BITS)) begin
      len_sat = LEN_W'(MAX_CODE_BITS);
    end else begin
      len_sat = LEN_W'(wr_len_i);
    end
    code_masked = wr_code_i[MAX_CODE_BITS-1:0] & ~({MAX_CODE_BITS{1'b1}} << len_sat);
  end

  // Single write port, single registered read port. A load and a later
  // encode of the same symbol hit the array on different edges, so the
  // read always sees the latest write.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[addr_i] <= {len_sat, code_masked};
    end
    if (ctl_i.rd_en) begin
      rd_q <= mem_q[addr_i];
    end
  end

  assign rd_code_o = rd_q[MAX_CODE_BITS-1:0];
  assign rd_len_o  = rd_q[ENTRY_W-1:MAX_CODE_BITS];

endmodule

// File: rtl/hcp_packer.sv
`include "huffman_code_packer_unit_assert.svh"

module hcp_packer #(
  parameter int unsigned WORD_BITS     = 256,
  parameter int unsigned MAX_CODE_BITS = 64,
  localparam int unsigned LEN_W  = $clog2(MAX_CODE_BITS + 1),
  localparam int unsigned FILL_W = $clog2(WORD_BITS + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  hcp_pkg::stage_req_t      req_i,
  output logic                     advance_o,
  input  logic [MAX_CODE_BITS-1:0] code_i,
  input  logic [LEN_W-1:0]         len_i,
  output hcp_pkg::emit_req_t       emit_o,
  output logic [WORD_BITS-1:0]     emit_word_o,
  input  logic                     emit_ready_i
);

  logic                 s1_valid_q, s1_valid_d;
  hcp_pkg::op_e         s1_op_q;
  logic [WORD_BITS-1:0] acc_q, acc_d;
  logic [FILL_W-1:0]    fill_q, fill_d;
  logic [FILL_W:0]      sum;
  logic                 fits;
  logic [FILL_W-1:0]    rest;
  logic [LEN_W-1:0]     spill;
  logic                 needs_emit;
  logic                 commit;
  logic [WORD_BITS-1:0] word;

  // Room check for the incoming code.
  assign sum   = (FILL_W + 1)'(fill_q) + (FILL_W + 1)'(len_i);
  assign fits  = sum <= (FILL_W + 1)'(WORD_BITS);
  assign rest  = FILL_W'(WORD_BITS) - fill_q;
  assign spill = len_i - LEN_W'(rest);

  // Accumulator update and word assembly.
  always_comb begin
    acc_d      = acc_q;
    fill_d     = fill_q;
    word       = '0;
    needs_emit = 1'b0;
    case (s1_op_q)
      hcp_pkg::OP_ENCODE: begin
        if (fits) begin
          acc_d  = (acc_q << len_i) | WORD_BITS'(code_i);
          fill_d = sum[FILL_W-1:0];
        end else begin
          // High bits of the code complete the word, low bits start the next.
          needs_emit = 1'b1;
          word       = (acc_q << rest) | WORD_BITS'(code_i >> spill);
          acc_d      = WORD_BITS'(code_i & ~({MAX_CODE_BITS{1'b1}} << spill));
          fill_d     = FILL_W'(spill);
        end
      end
      hcp_pkg::OP_FLUSH: begin
        needs_emit = 1'b1;
        word       = acc_q << (FILL_W'(WORD_BITS) - fill_q);
        acc_d      = '0;
        fill_d     = '0;
      end
      default: begin
        acc_d  = acc_q;
        fill_d = fill_q;
      end
    endcase
  end

  // The stage moves on unless it holds a word that the output cannot take.
  assign advance_o = !s1_valid_q || !needs_emit || emit_ready_i;
  assign commit    = s1_valid_q && advance_o;

  assign emit_o.valid = s1_valid_q && needs_emit && emit_ready_i;
  assign emit_o.valid_bits = (s1_op_q == hcp_pkg::OP_FLUSH)
                           ? hcp_pkg::VBITS_W'(fill_q)
                           : hcp_pkg::VBITS_W'(WORD_BITS);
  assign emit_word_o = word;

  // Stage occupancy.
  always_comb begin
    if (req_i.valid) begin
      s1_valid_d = 1'b1;
    end else if (advance_o) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      acc_q      <= '0;
      fill_q     <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (commit) begin
        acc_q  <= acc_d;
        fill_q <= fill_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      s1_op_q <= req_i.op;
    end
  end

  `HCP_ASSERT(a_fill_range, clk_i, rst_ni, fill_q <= FILL_W'(WORD_BITS))
  `HCP_ASSERT(a_acc_clean, clk_i, rst_ni, (acc_q >> fill_q) == '0)
  `HCP_ASSERT(a_stall_holds, clk_i, rst_ni, s1_valid_q && !advance_o |=> s1_valid_q && $stable(fill_q))

endmodule

// File: rtl/hcp_out_buf.sv
`include "huffman_code_packer_unit_assert.svh"

module hcp_out_buf #(
  parameter int unsigned WORD_BITS = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hcp_pkg::emit_req_t            emit_i,
  input  logic [WORD_BITS-1:0]          emit_word_i,
  output logic                          emit_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [hcp_pkg::CHUNK_W-1:0]   word_chunk_o,
  output logic [hcp_pkg::IDX_W-1:0]     chunk_index_o,
  output logic                          last_chunk_o,
  output logic [hcp_pkg::VBITS_W-1:0]   valid_bits_o
);

  localparam int unsigned CHUNKS = (WORD_BITS + hcp_pkg::CHUNK_W - 1) / hcp_pkg::CHUNK_W;
  localparam int unsigned BUF_W  = CHUNKS * hcp_pkg::CHUNK_W;
  localparam int unsigned PAD    = BUF_W - WORD_BITS;

  logic                          busy_q, busy_d;
  logic [hcp_pkg::IDX_W-1:0]     cnt_q, cnt_d;
  logic [BUF_W-1:0]              buf_q;
  logic [hcp_pkg::VBITS_W-1:0]   vbits_q;
  logic [hcp_pkg::IDX_W-1:0]     sel;
  logic                          out_fire;

  // Chunk selection, most significant chunk first.
  assign sel           = hcp_pkg::IDX_W'(CHUNKS - 1) - cnt_q;
  assign word_chunk_o  = buf_q[sel*hcp_pkg::CHUNK_W +: hcp_pkg::CHUNK_W];
  assign chunk_index_o = cnt_q;
  assign last_chunk_o  = cnt_q == hcp_pkg::IDX_W'(CHUNKS - 1);
  assign valid_bits_o  = vbits_q;
  assign out_valid_o   = busy_q;
  assign out_fire      = busy_q && out_ready_i;

  // A new word may enter as the last chunk of the current one leaves.
  assign emit_ready_o = !busy_q || (out_ready_i && last_chunk_o);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (emit_i.valid) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (out_fire && last_chunk_o) begin
      busy_d = 1'b0;
      cnt_d  = '0;
    end else if (out_fire) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Word is left-aligned in the buffer with zero padding after its LSB.
  always_ff @(posedge clk_i) begin
    if (emit_i.valid) begin
      buf_q   <= BUF_W'(emit_word_i) << PAD;
      vbits_q <= emit_i.valid_bits;
    end
  end

  `HCP_ASSERT(a_emit_when_free, clk_i, rst_ni, emit_i.valid |-> !busy_q || (out_fire && last_chunk_o))
  `HCP_ASSERT(a_cnt_steps, clk_i, rst_ni, out_fire && !last_chunk_o |=> cnt_q == hcp_pkg::IDX_W'($past(cnt_q) + 1'b1))
  `HCP_ASSERT(a_vbits_hold, clk_i, rst_ni, busy_q && !(out_fire && last_chunk_o) |=> $stable(vbits_q))

endmodule
